// File: rtl/priority_round_robin_scheduler_unit_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH

// Property checked on every rising edge of clk_i outside reset.
`define PRRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define PRRS_ASSERT_NEVER(lbl, cond, msg) \
  `PRRS_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/prrs_pkg.sv
// Shared constants, codes and word types of the priority round-robin scheduler.
package prrs_pkg;

  localparam int NUM_LEVELS  = 7;
  localparam int POOL_DEPTH  = 32;
  localparam int THREAD_BITS = 8;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W = PTR_W + 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

  localparam int TID_W    = 8;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  // A link at or above the pool depth marks the end of a list.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

  typedef enum logic [0:0] {
    REQ_INSERT   = 1'b0,
    REQ_SCHEDULE = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [TID_W-1:0]  thread_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0] chosen_thread;
    status_e          status;
  } rsp_t;

  typedef struct packed {
    logic [THREAD_BITS-1:0] thread;
    logic [LINK_W-1:0]      next;
  } element_t;

  typedef struct packed {
    logic             ins_en;
    logic [LVL_W-1:0] ins_lvl;
    logic [PTR_W-1:0] ins_slot;
    logic             adv_en;
    logic [LVL_W-1:0] adv_lvl;
    logic [PTR_W-1:0] adv_ptr;
  } qtab_cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0]      top_lvl;
    logic                  top_ne;
    logic                  rd_ne;
    logic [LINK_W-1:0]     rd_head;
    logic [PTR_W-1:0]      rd_cur;
    logic [NUM_LEVELS-1:0] ne;
  } qtab_view_t;

endpackage

// File: rtl/prrs_pool.sv
// Element pool memory: thread id and next link per element, one write and one read port.
module prrs_pool import prrs_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PTR_W-1:0] waddr_i,
  input  element_t         wdata_i,
  input  logic [PTR_W-1:0] raddr_i,
  output element_t         rdata_o
);

  element_t pool_mem_q [POOL_DEPTH];
  element_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pool_mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= pool_mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/prrs_qtab.sv
// Per-level queue table: list head, round-robin position, occupancy and top level.
module prrs_qtab import prrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] rd_lvl_i,
  input  qtab_cmd_t        cmd_i,
  output qtab_view_t       view_o
);

  logic [LINK_W-1:0]     head_q [NUM_LEVELS];
  logic [PTR_W-1:0]      cur_q  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ne_q;
  logic [LVL_W-1:0]      top_q;

  // Levels never drain, so the top level is simply the highest level ever inserted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= NULL_LINK;
        cur_q[i]  <= '0;
      end
      ne_q  <= '0;
      top_q <= '0;
    end else begin
      if (cmd_i.ins_en) begin
        head_q[cmd_i.ins_lvl] <= {1'b0, cmd_i.ins_slot};
        if (!ne_q[cmd_i.ins_lvl]) begin
          cur_q[cmd_i.ins_lvl] <= cmd_i.ins_slot;
        end
        ne_q[cmd_i.ins_lvl] <= 1'b1;
        if (cmd_i.ins_lvl > top_q) begin
          top_q <= cmd_i.ins_lvl;
        end
      end
      if (cmd_i.adv_en) begin
        cur_q[cmd_i.adv_lvl] <= cmd_i.adv_ptr;
      end
    end
  end

  assign view_o.top_lvl = top_q;
  assign view_o.top_ne  = ne_q[top_q];
  assign view_o.rd_ne   = ne_q[rd_lvl_i];
  assign view_o.rd_head = head_q[rd_lvl_i];
  assign view_o.rd_cur  = cur_q[rd_lvl_i];
  assign view_o.ne      = ne_q;

endmodule

// File: rtl/priority_round_robin_scheduler_unit.sv
// Top level of the priority round-robin scheduler: request sequencer and result register.
// An insert's result word is valid on the cycle after acceptance unless the output stalls.
// A schedule reads the pool twice: the current element, then its successor.
// A schedule that finds every level empty answers like an insert.
// Reset empties all levels and the pool at once; pool contents stay unwritten until inserted.
module priority_round_robin_scheduler_unit import prrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_word_o
);

  `include "priority_round_robin_scheduler_unit_macros.svh"

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LINK   = 2'd1;
  localparam logic [1:0] S_THREAD = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [CNT_W-1:0] used_q, used_d;
  rsp_t             hold_q;
  rsp_t             out_q;
  logic             out_valid_q;

  logic             accept;
  logic             is_sched;
  logic             full;
  logic             out_free;
  logic [LVL_W-1:0] ins_lvl;
  logic [LVL_W-1:0] rd_lvl;
  logic [PTR_W-1:0] nxt_ptr;
  logic [PTR_W-1:0] raddr;
  logic             pool_we;
  element_t         wdata;
  element_t         rdata;
  qtab_cmd_t        cmd;
  qtab_view_t       view;
  logic             fin_valid;
  rsp_t             fin_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_sched   = (in_word_i.req_type == REQ_SCHEDULE);
  assign full       = (used_q == CNT_W'(POOL_DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ins_lvl = (in_word_i.priority_req >= PRIO_W'(NUM_LEVELS)) ?
                   LVL_W'(NUM_LEVELS - 1) : LVL_W'(in_word_i.priority_req);

  always_comb begin
    if (state_q == S_IDLE) begin
      rd_lvl = is_sched ? view.top_lvl : ins_lvl;
    end else begin
      rd_lvl = lvl_q;
    end
  end

  // Past the end of a list the walk wraps to the head of the level.
  always_comb begin
    if (rdata.next < NULL_LINK) begin
      nxt_ptr = rdata.next[PTR_W-1:0];
    end else if (view.rd_head < NULL_LINK) begin
      nxt_ptr = view.rd_head[PTR_W-1:0];
    end else begin
      nxt_ptr = '0;
    end
  end

  assign wdata.thread = THREAD_BITS'(in_word_i.thread_id);
  assign wdata.next   = view.rd_head;

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    used_d    = used_q;
    raddr     = view.rd_cur;
    pool_we   = 1'b0;
    cmd       = '0;
    fin_valid = 1'b0;
    fin_rsp.chosen_thread = '0;
    fin_rsp.status        = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_sched) begin
            if (view.rd_ne) begin
              lvl_d   = view.top_lvl;
              state_d = S_LINK;
            end else begin
              fin_valid      = 1'b1;
              fin_rsp.status = ST_EMPTY;
            end
          end else begin
            fin_valid = 1'b1;
            if (full) begin
              fin_rsp.status = ST_FULL;
            end else begin
              pool_we      = 1'b1;
              cmd.ins_en   = 1'b1;
              cmd.ins_lvl  = ins_lvl;
              cmd.ins_slot = used_q[PTR_W-1:0];
              used_d       = used_q + CNT_W'(1);
            end
          end
        end
      end
      S_LINK: begin
        raddr       = nxt_ptr;
        cmd.adv_en  = 1'b1;
        cmd.adv_lvl = lvl_q;
        cmd.adv_ptr = nxt_ptr;
        state_d     = S_THREAD;
      end
      S_THREAD: begin
        fin_valid             = 1'b1;
        fin_rsp.chosen_thread = TID_W'(rdata.thread);
      end
      S_HOLD: begin
        fin_valid = 1'b1;
        fin_rsp   = hold_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin_valid) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      used_q  <= used_d;
      if (fin_valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid && out_free) begin
      out_q <= fin_rsp;
    end
    if (fin_valid && !out_free) begin
      hold_q <= fin_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  prrs_pool u_pool (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (used_q[PTR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  prrs_qtab u_qtab (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_lvl_i (rd_lvl),
    .cmd_i    (cmd),
    .view_o   (view)
  );

  `PRRS_ASSERT(a_top_level_occupied, (|view.ne) |-> view.top_ne, "top level is empty while another level holds threads")
  `PRRS_ASSERT(a_walk_on_occupied_level, (state_q == S_LINK) |-> view.rd_ne, "list walk on an empty level")
  `PRRS_ASSERT_NEVER(a_pool_overrun, used_q > CNT_W'(POOL_DEPTH), "pool allocation count beyond depth")
  `PRRS_ASSERT(a_full_insert_no_alloc, (accept && !is_sched && full) |=> $stable(used_q), "insert into a full pool allocated an element")

endmodule

// File: tb/tb_priority_round_robin_scheduler_unit.sv
// Self-checking testbench for the priority round-robin scheduler, with its own scheduler model.
module tb_priority_round_robin_scheduler_unit;
  import prrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 200000;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_word_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_word_o;

  priority_round_robin_scheduler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Model of the scheduler state.
  logic [THREAD_BITS-1:0] pool_thread [POOL_DEPTH];
  logic [LINK_W-1:0]      pool_next   [POOL_DEPTH];
  logic [LINK_W-1:0]      level_head  [NUM_LEVELS];
  logic [PTR_W-1:0]       level_cur   [NUM_LEVELS];
  int unsigned            level_count [NUM_LEVELS];
  int unsigned            used_slots  = 0;
  int unsigned            top_level   = 0;

  rsp_t        expected_rsp [$];
  int unsigned fail_count   = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned cycle_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      level_head[i]  = NULL_LINK;
      level_cur[i]   = '0;
      level_count[i] = 0;
    end
  end

  function automatic rsp_t predict_response(input req_t word);
    rsp_t        rsp;
    int unsigned lvl;
    int unsigned slot;
    logic [LINK_W-1:0] nxt;
    rsp.chosen_thread = '0;
    rsp.status        = ST_OK;
    if (word.req_type == REQ_INSERT) begin
      if (used_slots >= POOL_DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        // Levels beyond the top one are folded onto it.
        lvl  = (word.priority_req >= NUM_LEVELS) ? NUM_LEVELS - 1 : word.priority_req;
        slot = used_slots;
        used_slots++;
        pool_thread[slot] = word.thread_id[THREAD_BITS-1:0];
        pool_next[slot]   = level_head[lvl];
        level_head[lvl]   = LINK_W'(slot);
        if (level_count[lvl] == 0) begin
          level_cur[lvl] = PTR_W'(slot);
        end
        level_count[lvl]++;
        if (lvl > top_level) begin
          top_level = lvl;
        end
      end
    end else begin
      while (top_level > 0 && level_count[top_level] == 0) begin
        top_level--;
      end
      if (level_count[top_level] == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        // Step along the list, wrapping from its tail back to the newest entry.
        nxt = pool_next[level_cur[top_level]];
        if (nxt >= POOL_DEPTH) begin
          nxt = level_head[top_level];
        end
        level_cur[top_level] = nxt[PTR_W-1:0];
        rsp.chosen_thread    = TID_W'(pool_thread[nxt[PTR_W-1:0]]);
      end
    end
    return rsp;
  endfunction

  function automatic req_t make_word(input req_e kind, input logic [TID_W-1:0] tid,
                                     input logic [PRIO_W-1:0] prio);
    req_t word;
    word.req_type     = kind;
    word.thread_id    = tid;
    word.priority_req = prio;
    return word;
  endfunction

  // Sends one word; valid is only lowered when a gap is actually taken.
  task automatic send_request(input req_t word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    expected_rsp.push_back(predict_response(word));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_rsp.size() != 0);
  endtask

  task automatic test_empty_schedule();
    send_request(make_word(REQ_SCHEDULE, 8'h00, 3'd0));
    send_request(make_word(REQ_SCHEDULE, 8'hFF, 3'd7));
  endtask

  task automatic test_round_robin_levels();
    send_request(make_word(REQ_INSERT, 8'h00, 3'd0));
    send_request(make_word(REQ_SCHEDULE, 8'h00, 3'd0));
    send_request(make_word(REQ_SCHEDULE, 8'h00, 3'd0));
    send_request(make_word(REQ_INSERT, 8'h81, 3'd2));
    send_request(make_word(REQ_INSERT, 8'h3C, 3'd2));
    repeat (3) send_request(make_word(REQ_SCHEDULE, 8'h55, 3'd5));
    send_request(make_word(REQ_INSERT, 8'hA5, 3'd3));
    send_request(make_word(REQ_INSERT, 8'hFF, 3'd6));
    // Level seven does not exist and lands on level six.
    send_request(make_word(REQ_INSERT, 8'h5A, 3'd7));
    repeat (3) send_request(make_word(REQ_SCHEDULE, 8'hAA, 3'd2));
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned send_idle,
                             input int unsigned recv_stall);
    req_e kind;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (n_items) begin
      // Inserts are kept rare so that the pool fills gradually amid scheduling.
      if ($urandom_range(15) == 0) begin
        kind = REQ_INSERT;
      end else begin
        kind = REQ_SCHEDULE;
      end
      send_request(make_word(kind, TID_W'($urandom_range(255)), PRIO_W'($urandom_range(7))));
    end
    wait_drained();
  endtask

  task automatic test_pool_full();
    idle_pct  = 0;
    stall_pct = 0;
    while (used_slots < POOL_DEPTH) begin
      send_request(make_word(REQ_INSERT, TID_W'($urandom_range(255)),
                             PRIO_W'($urandom_range(7))));
    end
    repeat (3) send_request(make_word(REQ_INSERT, TID_W'($urandom_range(255)),
                                      PRIO_W'($urandom_range(7))));
    repeat (3) send_request(make_word(REQ_SCHEDULE, 8'h00, 3'd0));
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: result word with none expected: expected nothing, actual %p",
                 $time, out_word_o);
        fail_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (out_word_o.chosen_thread !== want.chosen_thread) begin
          $display("%0t: chosen_thread mismatch: expected %0h, actual %0h",
                   $time, want.chosen_thread, out_word_o.chosen_thread);
          fail_count++;
        end
        if (out_word_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_word_o.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL priority_round_robin_scheduler_unit");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_schedule();
    test_round_robin_levels();
    test_random(155, 0, 0);
    test_random(155, 47, 0);
    test_random(155, 0, 47);
    test_random(155, 13, 13);
    test_pool_full();
    repeat (8) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_rsp.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS priority_round_robin_scheduler_unit");
    end else begin
      $display("FAIL priority_round_robin_scheduler_unit");
    end
    $finish;
  end

endmodule
